// ===== sv/mhpq_pkg.sv =====
// Shared types and constants of the max-heap priority queue.
// Holds the action codes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package mhpq_pkg;

    // Default build sizes.
    localparam int CAPACITY_DEF      = 64;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int PAYLOAD_BITS_DEF  = 32;

    // Width and reset value of the capacity limit register.
    localparam int             LIMIT_BITS  = 7;
    localparam logic [6:0]     LIMIT_RESET = 7'd64;

    // Action codes of an input item.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    // Read address select of the entry memory.
    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    // Write data select; the write address is always the current position.
    typedef enum logic [1:0] {
        WR_HOLD,
        WR_RDATA,
        WR_LEFT
    } wr_sel_t;

    // Next value select of the position register.
    typedef enum logic [2:0] {
        POS_KEEP,
        POS_COUNT,
        POS_ZERO,
        POS_PARENT,
        POS_LEFT,
        POS_RIGHT
    } pos_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     hold_load_item;
        logic     hold_load_rd;
        logic     left_load;
        pos_sel_t pos_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_clear;
        logic     res_load_rd;
        logic     res_drop;
        logic     out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic left_in;
        logic right_in;
        logic hold_gt_rd;
        logic hold_lt_rd;
        logic hold_lt_left;
        logic rd_gt_left;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/mhpq_dpath.sv =====
// Datapath of the max-heap priority queue: entry memory, count, sift registers,
// result and output registers. Driven by mhpq_ctrl through dp_cmd_t.
// Depends on mhpq_pkg.
`default_nettype none

module mhpq_dpath #(
    parameter int CAPACITY      = mhpq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = mhpq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = mhpq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mhpq_pkg::dp_cmd_t               cmd,
    output mhpq_pkg::dp_stat_t                   stat,
    input  wire logic [mhpq_pkg::LIMIT_BITS-1:0] cap_limit,
    input  wire logic [PRIORITY_BITS-1:0]        item_priority,
    input  wire logic [PAYLOAD_BITS-1:0]         item_payload,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic                                 result_valid,
    output logic [PRIORITY_BITS-1:0]             out_priority,
    output logic [PAYLOAD_BITS-1:0]              out_payload,
    output logic                                 insert_dropped,
    output logic                                 now_empty
);
    import mhpq_pkg::*;

    localparam int EW   = PRIORITY_BITS + PAYLOAD_BITS;
    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (IW + 2 > CW) ? IW + 2 : CW;
    localparam int LW   = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

    // Entry memory: priority in the upper bits, payload in the lower bits.
    logic [EW-1:0] mem [CAPACITY];

    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            pos_reg, pos_next;
    logic [EW-1:0]            hold_reg;
    logic [EW-1:0]            left_reg;
    logic [EW-1:0]            rd_data_reg;
    logic                     res_valid_reg;
    logic [EW-1:0]            res_entry_reg;
    logic                     res_drop_reg;
    logic                     out_valid_reg;
    logic                     out_rvalid_reg;
    logic [EW-1:0]            out_entry_reg;
    logic                     out_drop_reg;
    logic                     out_empty_reg;

    logic [IW-1:0]            rd_addr;
    logic [EW-1:0]            wr_data;
    logic [IW+1:0]            left_w;
    logic [IW+1:0]            right_w;
    logic [IW-1:0]            left_idx;
    logic [IW-1:0]            right_idx;
    logic [IW-1:0]            parent_idx;
    logic [CW-1:0]            last_w;
    logic [PRIORITY_BITS-1:0] hold_prio;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [PRIORITY_BITS-1:0] left_prio;

    // Heap index arithmetic around the current position.
    assign left_w     = {1'b0, pos_reg, 1'b1};
    assign right_w    = {1'b0, pos_reg, 1'b0} + (IW + 2)'(2);
    assign left_idx   = left_w[IW-1:0];
    assign right_idx  = right_w[IW-1:0];
    assign parent_idx = (pos_reg - IW'(1)) >> 1;
    assign last_w     = count_reg - CW'(1);

    assign hold_prio  = hold_reg[EW-1 -: PRIORITY_BITS];
    assign rd_prio    = rd_data_reg[EW-1 -: PRIORITY_BITS];
    assign left_prio  = left_reg[EW-1 -: PRIORITY_BITS];

    // Status toward the controller.
    always_comb
    begin
        stat.full         = (LW'(count_reg) >= LW'(cap_limit)) ||
                            (count_reg >= CW'(CAPACITY));
        stat.empty        = (count_reg == '0);
        stat.at_root      = (pos_reg == '0);
        stat.left_in      = (CMPW'(left_w) < CMPW'(count_reg));
        stat.right_in     = (CMPW'(right_w) < CMPW'(count_reg));
        stat.hold_gt_rd   = (hold_prio > rd_prio);
        stat.hold_lt_rd   = (hold_prio < rd_prio);
        stat.hold_lt_left = (hold_prio < left_prio);
        stat.rd_gt_left   = (rd_prio > left_prio);
        stat.out_busy     = out_valid_reg && !out_ready;
    end

    // Read address and write data selection.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_ROOT:   rd_addr = '0;
            RD_LAST:   rd_addr = last_w[IW-1:0];
            RD_PARENT: rd_addr = parent_idx;
            RD_LEFT:   rd_addr = left_idx;
            RD_RIGHT:  rd_addr = right_idx;
            default:   rd_addr = '0;
        endcase
        case (cmd.wr_sel)
            WR_HOLD:  wr_data = hold_reg;
            WR_RDATA: wr_data = rd_data_reg;
            WR_LEFT:  wr_data = left_reg;
            default:  wr_data = hold_reg;
        endcase
    end

    // Next position and count.
    always_comb
    begin
        case (cmd.pos_sel)
            POS_KEEP:   pos_next = pos_reg;
            POS_COUNT:  pos_next = count_reg[IW-1:0];
            POS_ZERO:   pos_next = '0;
            POS_PARENT: pos_next = parent_idx;
            POS_LEFT:   pos_next = left_idx;
            POS_RIGHT:  pos_next = right_idx;
            default:    pos_next = pos_reg;
        endcase
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = last_w;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sift registers and result payload.
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.hold_load_item)
        begin
            hold_reg <= {item_priority, item_payload};
        end
        else if (cmd.hold_load_rd)
        begin
            hold_reg <= rd_data_reg;
        end
        if (cmd.left_load)
        begin
            left_reg <= rd_data_reg;
        end
        if (cmd.res_clear)
        begin
            res_entry_reg <= '0;
        end
        else if (cmd.res_load_rd)
        begin
            res_entry_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            out_entry_reg <= res_entry_reg;
            out_rvalid_reg <= res_valid_reg;
            out_drop_reg  <= res_drop_reg;
            out_empty_reg <= (count_reg == '0);
        end
    end

    // Control state: count, result flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_drop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.res_clear)
            begin
                // A refused insert is flagged in the same cycle that starts the item.
                res_valid_reg <= 1'b0;
                res_drop_reg  <= cmd.res_drop;
            end
            else
            begin
                if (cmd.res_load_rd)
                begin
                    res_valid_reg <= 1'b1;
                end
                if (cmd.res_drop)
                begin
                    res_drop_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_valid   = out_rvalid_reg;
    assign out_priority   = out_entry_reg[EW-1 -: PRIORITY_BITS];
    assign out_payload    = out_entry_reg[PAYLOAD_BITS-1:0];
    assign insert_dropped = out_drop_reg;
    assign now_empty      = out_empty_reg;

    // The count never passes the built capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // An insert only grows a heap that has room.
    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !stat.full)
        else $error("count incremented on a full heap");

    // A remove only shrinks a heap that holds entries.
    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("count decremented on an empty heap");

    // A finished result never overwrites one still waiting for transfer.
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("output register overwritten");

    // A returned entry and a dropped insert never come together.
    a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_rvalid_reg && out_drop_reg))
        else $error("result valid together with insert dropped");

endmodule

`default_nettype wire

// ===== sv/mhpq_ctrl.sv =====
// Controller of the max-heap priority queue: sequences insert, remove and peek
// over the datapath, one memory read per cycle. Depends on mhpq_pkg.
`default_nettype none

module mhpq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        action,
    input  wire mhpq_pkg::dp_stat_t stat,
    output logic                   in_ready,
    output mhpq_pkg::dp_cmd_t      cmd
);
    import mhpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_CHK,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_PK_ROOT,
        S_FIN
    } state_t;

    state_t  state_reg, state_next;
    action_t act;

    assign act      = action_t'(action);
    assign in_ready = (state_reg == S_IDLE);

    // Command decode and next state.
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_ROOT;
        cmd.wr_sel     = WR_HOLD;
        cmd.pos_sel    = POS_KEEP;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.res_clear      = 1'b1;
                    cmd.hold_load_item = 1'b1;
                    case (act)
                        ACT_INSERT:
                        begin
                            if (stat.full)
                            begin
                                cmd.res_drop = 1'b1;
                                state_next   = S_FIN;
                            end
                            else
                            begin
                                cmd.pos_sel = POS_COUNT;
                                cmd.cnt_inc = 1'b1;
                                state_next  = S_UP_CHK;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (stat.empty)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_ROOT;
                                state_next = S_RM_ROOT;
                            end
                        end
                        ACT_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_ROOT;
                                state_next = S_PK_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            // Sift-up: fetch the parent unless the hole reached the root.
            S_UP_CHK:
            begin
                if (stat.at_root)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_HOLD;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            // Move the parent down while the new entry is strictly larger.
            S_UP_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.hold_gt_rd)
                begin
                    cmd.wr_sel  = WR_RDATA;
                    cmd.pos_sel = POS_PARENT;
                    state_next  = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_sel = WR_HOLD;
                    state_next = S_FIN;
                end
            end
            // Capture the root as the result and fetch the last entry.
            S_RM_ROOT:
            begin
                cmd.res_load_rd = 1'b1;
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = RD_LAST;
                cmd.cnt_dec     = 1'b1;
                state_next      = S_RM_LAST;
            end
            // The last entry becomes the one sifted down from the root.
            S_RM_LAST:
            begin
                cmd.hold_load_rd = 1'b1;
                cmd.pos_sel      = POS_ZERO;
                state_next       = stat.empty ? S_FIN : S_DN_CHK;
            end
            // Sift-down: fetch the left child if it lies within the count.
            S_DN_CHK:
            begin
                if (stat.left_in)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LEFT;
                    state_next = S_DN_LEFT;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_HOLD;
                    state_next = S_FIN;
                end
            end
            // Keep the left child; fetch the right one or decide on the left alone.
            S_DN_LEFT:
            begin
                cmd.left_load = 1'b1;
                if (stat.right_in)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_RIGHT;
                    state_next = S_DN_RIGHT;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    if (stat.hold_lt_rd)
                    begin
                        cmd.wr_sel  = WR_RDATA;
                        cmd.pos_sel = POS_LEFT;
                        state_next  = S_DN_CHK;
                    end
                    else
                    begin
                        cmd.wr_sel = WR_HOLD;
                        state_next = S_FIN;
                    end
                end
            end
            // The right child wins only when strictly larger than the left.
            S_DN_RIGHT:
            begin
                cmd.wr_en = 1'b1;
                if (stat.rd_gt_left)
                begin
                    if (stat.hold_lt_rd)
                    begin
                        cmd.wr_sel  = WR_RDATA;
                        cmd.pos_sel = POS_RIGHT;
                        state_next  = S_DN_CHK;
                    end
                    else
                    begin
                        cmd.wr_sel = WR_HOLD;
                        state_next = S_FIN;
                    end
                end
                else if (stat.hold_lt_left)
                begin
                    cmd.wr_sel  = WR_LEFT;
                    cmd.pos_sel = POS_LEFT;
                    state_next  = S_DN_CHK;
                end
                else
                begin
                    cmd.wr_sel = WR_HOLD;
                    state_next = S_FIN;
                end
            end
            S_PK_ROOT:
            begin
                cmd.res_load_rd = 1'b1;
                state_next      = S_FIN;
            end
            // Hand the result to the output register once it is free.
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Memory writes are issued only in a sift step.
    a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg == S_UP_CHK || state_reg == S_UP_CMP ||
                       state_reg == S_DN_CHK || state_reg == S_DN_LEFT ||
                       state_reg == S_DN_RIGHT))
        else $error("memory write outside a sift step");

    // An accepted item always leaves the idle state.
    a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");

    // The count only moves on an insert start or a remove.
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_inc || cmd.cnt_dec) |->
            (state_reg == S_IDLE || state_reg == S_RM_ROOT))
        else $error("count changed outside insert or remove");

endmodule

`default_nettype wire

// ===== sv/max_heap_priority_queue_core.sv =====
// Top level of the binary max-heap priority queue: controller plus datapath.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dpath.
//
//   Channel   Handshake              Contents
//   input     in_valid / in_ready    action, item_priority, item_payload
//   output    out_valid / out_ready  result_valid, out_priority, out_payload,
//                                    insert_dropped, now_empty
//   config    cfg_valid / cfg_ready  capacity_limit
//
// One item is worked at a time; the entry memory gives one registered read per cycle.
// Insert compares the new entry with one parent after another; a dropped insert skips that.
// Remove takes the root, fetches the last entry and compares children level by level;
// peek reads the root only. An empty heap and the idle action read no memory.
// A sift passes at most log2(CAPACITY) levels.
// Reset empties the heap (count zero) and sets the limit to 64; no memory clear pass.
// A new item transfers while the previous result still waits in the output register;
// a result that finds that register occupied waits in the controller.
`default_nettype none

module max_heap_priority_queue_core #(
    parameter int CAPACITY      = mhpq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = mhpq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = mhpq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mhpq_pkg::LIMIT_BITS-1:0] capacity_limit,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      action,
    input  wire logic [PRIORITY_BITS-1:0]        item_priority,
    input  wire logic [PAYLOAD_BITS-1:0]         item_payload,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 result_valid,
    output logic [PRIORITY_BITS-1:0]             out_priority,
    output logic [PAYLOAD_BITS-1:0]              out_payload,
    output logic                                 insert_dropped,
    output logic                                 now_empty
);
    import mhpq_pkg::*;

    logic [LIMIT_BITS-1:0] cap_limit_reg;
    dp_cmd_t               cmd;
    dp_stat_t              stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            cap_limit_reg <= capacity_limit;
        end
    end

    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mhpq_dpath #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cap_limit      (cap_limit_reg),
        .item_priority  (item_priority),
        .item_payload   (item_payload),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .result_valid   (result_valid),
        .out_priority   (out_priority),
        .out_payload    (out_payload),
        .insert_dropped (insert_dropped),
        .now_empty      (now_empty)
    );

endmodule

`default_nettype wire

// ===== tb/max_heap_priority_queue_checker.sv =====
// Checker for the max-heap priority queue core: watches the config, input and output channels.
// Keeps its own copy of the heap and limit, predicts each result and compares it field by field.
// Depends on mhpq_pkg for the action codes and the limit reset value.
module max_heap_priority_queue_checker
    import mhpq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [LIMIT_BITS-1:0]    capacity_limit,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [1:0]               action,
    input  logic [PRIORITY_BITS-1:0] item_priority,
    input  logic [PAYLOAD_BITS-1:0]  item_payload,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     result_valid,
    input  logic [PRIORITY_BITS-1:0] out_priority,
    input  logic [PAYLOAD_BITS-1:0]  out_payload,
    input  logic                     insert_dropped,
    input  logic                     now_empty,
    output int                       results_owed,
    output int                       error_count
);

    // One predicted result of the queue.
    typedef struct packed {
        logic                     valid;
        logic [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  tag;
        logic                     dropped;
        logic                     empty;
    } heap_result_t;

    // Shadow heap and limit register.
    logic [PRIORITY_BITS-1:0] heap_prio [CAPACITY];
    logic [PAYLOAD_BITS-1:0]  heap_tag  [CAPACITY];
    int                       heap_size;
    logic [LIMIT_BITS-1:0]    limit_reg;

    heap_result_t owed_results[$];
    int           result_index;
    int           shown_errors;

    // Exchange two heap slots.
    task automatic swap_slots(input int a, input int b);
        logic [PRIORITY_BITS-1:0] tp;
        logic [PAYLOAD_BITS-1:0]  tt;
        begin
            tp = heap_prio[a];
            tt = heap_tag[a];
            heap_prio[a] = heap_prio[b];
            heap_tag[a]  = heap_tag[b];
            heap_prio[b] = tp;
            heap_tag[b]  = tt;
        end
    endtask

    // Apply one request to the shadow heap and work out its result.
    task automatic heap_apply(
        input  action_t                  act,
        input  logic [PRIORITY_BITS-1:0] prio,
        input  logic [PAYLOAD_BITS-1:0]  tag,
        output heap_result_t             res
    );
        int   eff_limit;
        int   pos;
        int   parent;
        int   pick;
        logic done;
        begin
            res = '0;
            eff_limit = (int'(limit_reg) < CAPACITY) ? int'(limit_reg) : CAPACITY;
            case (act)
                ACT_INSERT:
                begin
                    if (heap_size < eff_limit)
                    begin
                        heap_prio[heap_size] = prio;
                        heap_tag[heap_size]  = tag;
                        pos  = heap_size;
                        done = 1'b0;
                        // Climb while strictly greater than the parent.
                        while (!done && pos > 0)
                        begin
                            parent = (pos - 1) / 2;
                            if (heap_prio[pos] > heap_prio[parent])
                            begin
                                swap_slots(pos, parent);
                                pos = parent;
                            end
                            else
                                done = 1'b1;
                        end
                        heap_size++;
                    end
                    else
                        res.dropped = 1'b1;
                end
                ACT_REMOVE:
                begin
                    if (heap_size > 0)
                    begin
                        res.valid = 1'b1;
                        res.prio  = heap_prio[0];
                        res.tag   = heap_tag[0];
                        heap_size--;
                        heap_prio[0] = heap_prio[heap_size];
                        heap_tag[0]  = heap_tag[heap_size];
                        heap_prio[heap_size] = '0;
                        heap_tag[heap_size]  = '0;
                        pos  = 0;
                        done = 1'b0;
                        // Descend toward the larger child; the right one wins only when
                        // it is inside the count and strictly larger.
                        while (!done && 2 * pos + 1 < heap_size)
                        begin
                            pick = 2 * pos + 1;
                            if (pick + 1 < heap_size && heap_prio[pick + 1] > heap_prio[pick])
                                pick++;
                            if (heap_prio[pos] < heap_prio[pick])
                            begin
                                swap_slots(pos, pick);
                                pos = pick;
                            end
                            else
                                done = 1'b1;
                        end
                    end
                end
                ACT_PEEK:
                begin
                    if (heap_size > 0)
                    begin
                        res.valid = 1'b1;
                        res.prio  = heap_prio[0];
                        res.tag   = heap_tag[0];
                    end
                end
                default:
                begin
                end
            endcase
            res.empty = (heap_size == 0);
        end
    endtask

    // Compare one field and report the first few differences.
    task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
        begin
            if (want !== got)
            begin
                error_count++;
                if (shown_errors < 10)
                begin
                    shown_errors++;
                    $display("result %0d: %s expected %0h, got %0h", result_index, field, want, got);
                end
            end
        end
    endtask

    // Track every transfer on the three channels.
    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t want;
        heap_result_t fresh;
        if (!rst_n)
        begin
            heap_size    = 0;
            limit_reg    = LIMIT_RESET;
            owed_results.delete();
            result_index = 0;
            shown_errors = 0;
            error_count  = 0;
            results_owed <= 0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                heap_prio[i] = '0;
                heap_tag[i]  = '0;
            end
        end
        else
        begin
            // The result leaving now belongs to an older request, so match it first.
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    error_count++;
                    if (shown_errors < 10)
                    begin
                        shown_errors++;
                        $display("result %0d arrived with no request waiting", result_index);
                    end
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("result_valid", 64'(want.valid), 64'(result_valid));
                    check_field("out_priority", 64'(want.prio), 64'(out_priority));
                    check_field("out_payload", 64'(want.tag), 64'(out_payload));
                    check_field("insert_dropped", 64'(want.dropped), 64'(insert_dropped));
                    check_field("now_empty", 64'(want.empty), 64'(now_empty));
                end
                result_index++;
            end
            if (cfg_valid && cfg_ready)
                limit_reg = capacity_limit;
            if (in_valid && in_ready)
            begin
                heap_apply(action_t'(action), item_priority, item_payload, fresh);
                owed_results.push_back(fresh);
            end
            results_owed <= owed_results.size();
        end
    end

endmodule

// ===== tb/max_heap_priority_queue_core_test.sv =====
// Top of the max-heap priority queue testbench: clock, reset, stimulus and the verdict.
// Instantiates max_heap_priority_queue_core and max_heap_priority_queue_checker.
// Depends on mhpq_pkg for the action codes and the limit width.
module max_heap_priority_queue_core_test;
    import mhpq_pkg::*;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [LIMIT_BITS-1:0] capacity_limit = LIMIT_RESET;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic [1:0]            action         = ACT_NOP;
    logic [15:0]           item_priority  = '0;
    logic [31:0]           item_payload   = '0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic                  result_valid;
    logic [15:0]           out_priority;
    logic [31:0]           out_payload;
    logic                  insert_dropped;
    logic                  now_empty;

    int results_owed;
    int error_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    max_heap_priority_queue_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_limit (capacity_limit),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .item_priority  (item_priority),
        .item_payload   (item_payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_valid   (result_valid),
        .out_priority   (out_priority),
        .out_payload    (out_payload),
        .insert_dropped (insert_dropped),
        .now_empty      (now_empty)
    );

    max_heap_priority_queue_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_limit (capacity_limit),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .item_priority  (item_priority),
        .item_payload   (item_payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_valid   (result_valid),
        .out_priority   (out_priority),
        .out_payload    (out_payload),
        .insert_dropped (insert_dropped),
        .now_empty      (now_empty),
        .results_owed   (results_owed),
        .error_count    (error_count)
    );

    // Clock with a period of 12.
    always #6 clk = ~clk;

    // Receiver back-pressure.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Hard stop for a hung run.
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one request, with an optional random gap first, and wait for its transfer.
    task automatic send_request(input action_t act, input logic [15:0] prio, input logic [31:0] tag);
        begin
            if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < send_idle_pct);
            end
            in_valid      <= 1'b1;
            action        <= act;
            item_priority <= prio;
            item_payload  <= tag;
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic wait_for_results();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (results_owed != 0)
                @(posedge clk);
        end
    endtask

    // Write the capacity limit while the queue is idle.
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        begin
            wait_for_results();
            cfg_valid      <= 1'b1;
            capacity_limit <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [LIMIT_BITS-1:0] phase_limit [10];
        int                    phase_bias  [10];
        int                    pick;
        action_t               act;
        logic [15:0]           prio;

        phase_limit = '{7'd64, 7'd127, 7'd7, 7'd2, 7'd0, 7'd64, 7'd1, 7'd100, 7'd0, 7'd64};
        phase_limit[8] = LIMIT_BITS'($urandom_range(127));
        // Bias per phase: 0 fill, 1 drain, 2 mixed.
        phase_bias = '{0, 0, 1, 2, 2, 0, 1, 0, 2, 1};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty heap, extremes, equal priorities and the default limit.
        send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);
        send_request(ACT_PEEK, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_NOP, 16'h1234, 32'h1234_5678);
        send_request(ACT_INSERT, 16'h0000, 32'h0000_0000);
        send_request(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 16'h8000, 32'hAAAA_AAAA);
        send_request(ACT_INSERT, 16'hFFFF, 32'h5555_5555);
        send_request(ACT_PEEK, 16'h0000, 32'h0000_0000);
        send_request(ACT_NOP, 16'h0000, 32'h0000_0000);
        send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);
        send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);
        send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);
        send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);
        send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);

        // Directed: a zero limit drops every insert.
        write_limit(7'd0);
        send_request(ACT_INSERT, 16'h7FFF, 32'h8000_0001);

        // Directed: a limit of one fills after a single insert.
        write_limit(7'd1);
        send_request(ACT_INSERT, 16'h00FF, 32'hDEAD_BEEF);
        send_request(ACT_INSERT, 16'hFF00, 32'h0BAD_F00D);
        send_request(ACT_PEEK, 16'h0000, 32'h0000_0000);
        send_request(ACT_REMOVE, 16'h0000, 32'h0000_0000);

        // Random phases; the heap is kept across phases so a lower limit finds it fuller.
        for (int p = 0; p < 10; p++)
        begin
            write_limit(phase_limit[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < 95; n++)
            begin
                pick = $urandom_range(99);
                case (phase_bias[p])
                    0:       act = (pick < 72) ? ACT_INSERT : (pick < 88) ? ACT_REMOVE :
                                   (pick < 96) ? ACT_PEEK : ACT_NOP;
                    1:       act = (pick < 20) ? ACT_INSERT : (pick < 80) ? ACT_REMOVE :
                                   (pick < 95) ? ACT_PEEK : ACT_NOP;
                    default: act = (pick < 45) ? ACT_INSERT : (pick < 80) ? ACT_REMOVE :
                                   (pick < 94) ? ACT_PEEK : ACT_NOP;
                endcase
                // Small priorities make ties common; the extremes show up too.
                pick = $urandom_range(99);
                if (pick < 30)
                    prio = 16'($urandom_range(7));
                else if (pick < 40)
                    prio = pick[0] ? 16'hFFFF : 16'h0000;
                else
                    prio = 16'($urandom);
                send_request(act, prio, $urandom);
                // Let the queue empty its output once in the middle of a phase.
                if (p == 3 && n == 40)
                    wait_for_results();
            end
        end

        // Drain and settle.
        wait_for_results();
        repeat (40) @(posedge clk);
        if (error_count == 0 && results_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== max_heap_priority_queue_core.f =====
sv/mhpq_pkg.sv
sv/mhpq_dpath.sv
sv/mhpq_ctrl.sv
sv/max_heap_priority_queue_core.sv
tb/max_heap_priority_queue_checker.sv
tb/max_heap_priority_queue_core_test.sv
